// ===== src/icf_pkg.sv =====
// Shared types and constants for the integer conversion formatter.
`default_nettype none
package icf_pkg;

    localparam logic [2:0] CONV_DEC  = 3'd0;
    localparam logic [2:0] CONV_UNS  = 3'd1;
    localparam logic [2:0] CONV_OCT  = 3'd2;
    localparam logic [2:0] CONV_HEXL = 3'd3;
    localparam logic [2:0] CONV_HEXU = 3'd4;
    localparam logic [2:0] CONV_PTR  = 3'd5;
    localparam logic [2:0] CONV_CHAR = 3'd6;
    localparam logic [2:0] CONV_PCT  = 3'd7;

    localparam int DIGIT_SLOTS = 22;
    localparam int PTR_DIGITS  = 16;

    typedef struct packed {
        logic [2:0]  conversion;
        logic [63:0] value;
        logic        long_argument;
        logic        alternate_form;
        logic        zero_pad;
        logic        left_align;
        logic        blank_sign;
        logic        plus_sign;
        logic [6:0]  field_width;
        logic        precision_given;
        logic [5:0]  precision;
    } conv_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } char_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIGITS,
        ST_PLAN,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        SEG_PRE_A,
        SEG_LPAD,
        SEG_PRE_B,
        SEG_PZERO,
        SEG_BODY,
        SEG_RPAD,
        SEG_DONE
    } seg_t;

    typedef struct packed {
        logic load;
        logic digit_step;
        logic plan;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic digits_done;
        logic emit_done;
    } status_t;

endpackage
`default_nettype wire

// ===== src/integer_conversion_formatter.sv =====
// Top level of the printf-style integer conversion formatter.
// Sequence: a load step, a digit loop (one step per octal or hex digit, a
// multi-phase step per decimal digit, one step for char and percent), a layout
// step, then one character beat per cycle. The block takes no new item until
// the last beat of the current one; reset is asynchronous and leaves it idle
// with no strobe.
`default_nettype none
module integer_conversion_formatter #(
    parameter int MAX_OUTPUT = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire icf_pkg::conv_in_t  request,
    output logic                    busy,
    output logic                    strobe,
    output icf_pkg::char_out_t      result
);

    icf_pkg::cmd_t    cmd;
    icf_pkg::status_t status;

    icf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    icf_datapath #(
        .MAX_OUTPUT (MAX_OUTPUT)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (request),
        .cmd    (cmd),
        .status (status),
        .strobe (strobe),
        .result (result)
    );

    a_no_strobe_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !strobe)
        else $error("strobe right after accept");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.digit_step, cmd.plan, cmd.emit_step}))
        else $error("controller issued overlapping commands");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |-> !busy)
        else $error("block still busy after last beat");

endmodule
`default_nettype wire

// ===== src/icf_ctrl.sv =====
// Controller state machine for the integer conversion formatter.
`default_nettype none
module icf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire icf_pkg::status_t status,
    output icf_pkg::cmd_t         cmd,
    output logic                  busy
);

    icf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= icf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            icf_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    cmd.load = 1'b1;
                    state_next = icf_pkg::ST_DIGITS;
                end
            end
            icf_pkg::ST_DIGITS: begin
                cmd.digit_step = 1'b1;
                if (status.digits_done) begin
                    state_next = icf_pkg::ST_PLAN;
                end
            end
            icf_pkg::ST_PLAN: begin
                cmd.plan = 1'b1;
                state_next = icf_pkg::ST_EMIT;
            end
            icf_pkg::ST_EMIT: begin
                cmd.emit_step = 1'b1;
                if (status.emit_done) begin
                    state_next = icf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = icf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/icf_datapath.sv =====
// Datapath: digit extraction, field layout and character emission.
`default_nettype none
module icf_datapath #(
    parameter int MAX_OUTPUT = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire icf_pkg::conv_in_t req,
    input  wire icf_pkg::cmd_t     cmd,
    output icf_pkg::status_t       status,
    output logic                   strobe,
    output icf_pkg::char_out_t     result
);

    localparam int CW = $clog2(MAX_OUTPUT + 1);
    localparam int KW = $clog2(icf_pkg::DIGIT_SLOTS + 1);
    localparam int DW = $clog2(icf_pkg::DIGIT_SLOTS);
    localparam logic [CW-1:0] MAX_W = CW'(MAX_OUTPUT);
    localparam logic [CW-1:0] MAX_P = CW'(MAX_OUTPUT - 2);
    localparam logic [1:0] DEC_LAST_PHASE = 2'd2;

    logic [2:0]  conv_reg;
    logic        alt_reg, zp_reg, left_reg, plus_reg, blank_reg, pg_reg;
    logic [CW-1:0] width_reg, prec_reg;
    logic [63:0] v_reg;
    logic        neg_reg, nz_reg;
    logic [7:0]  digits_reg [icf_pkg::DIGIT_SLOTS];
    logic [KW-1:0] k_reg;
    logic [7:0]  pre0_reg, pre1_reg;
    logic [1:0]  npre_reg;
    logic [CW-1:0] pad_reg, pz_reg, cnt_reg;
    icf_pkg::seg_t seg_reg, seg_next;
    logic        strobe_reg;
    icf_pkg::char_out_t result_reg;
    logic [1:0]  phase_reg;
    logic [63:0] qacc_reg;

    logic [CW-1:0] width_c, prec_c;
    logic          lng;
    logic [63:0]   s_ext, mag;
    logic          neg;
    logic          numeric;

    always_comb begin
        width_c = (int'(req.field_width) > MAX_OUTPUT) ? MAX_W : CW'(req.field_width);
        prec_c = (int'(req.precision) > MAX_OUTPUT - 2) ? MAX_P : CW'(req.precision);
        lng = req.long_argument || (req.conversion == icf_pkg::CONV_PTR);
        s_ext = lng ? req.value : {{32{req.value[31]}}, req.value[31:0]};
        neg = (req.conversion == icf_pkg::CONV_DEC) && s_ext[63];
        if (req.conversion == icf_pkg::CONV_DEC) begin
            mag = neg ? (64'd0 - s_ext) : s_ext;
        end else begin
            mag = lng ? req.value : {32'd0, req.value[31:0]};
        end
    end

    // Octal and hex take one digit a cycle. A decimal digit is formed in phases:
    // the quotient by ten is estimated from shifts and adds in the early phases,
    // and the last phase scales it, forms the remainder on five bits (the estimate
    // is at most one low) and corrects it.
    logic [3:0]  dig;
    logic [63:0] v_nx;
    logic [7:0]  dig_ch;
    logic [63:0] q_p0, q_s0, q_s1, q_s1b, q_s2, q_est;
    logic [4:0]  r5;
    logic        r_hi;
    logic        dec_mode;
    logic        dig_final;

    always_comb begin
        q_p0 = (v_reg >> 1) + (v_reg >> 2);
        q_s0 = q_p0 + (q_p0 >> 4);
        q_s1 = qacc_reg + (qacc_reg >> 8);
        q_s1b = q_s1 + (q_s1 >> 16);
        q_s2 = qacc_reg + (qacc_reg >> 32);
        q_est = q_s2 >> 3;
        r5 = v_reg[4:0] - ((q_est[4:0] << 3) + (q_est[4:0] << 1));
        r_hi = (r5 > 5'd9);
        dec_mode = 1'b0;
        dig = '0;
        v_nx = '0;
        unique case (conv_reg)
            icf_pkg::CONV_OCT: begin
                dig = {1'b0, v_reg[2:0]};
                v_nx = v_reg >> 3;
            end
            icf_pkg::CONV_HEXL, icf_pkg::CONV_HEXU, icf_pkg::CONV_PTR: begin
                dig = v_reg[3:0];
                v_nx = v_reg >> 4;
            end
            default: begin
                dec_mode = 1'b1;
                dig = r_hi ? 4'(r5 - 5'd10) : r5[3:0];
                v_nx = q_est + {63'd0, r_hi};
            end
        endcase
        dig_final = !dec_mode || (phase_reg == DEC_LAST_PHASE);
        if (dig < 4'd10) begin
            dig_ch = 8'h30 + {4'd0, dig};
        end else if (conv_reg == icf_pkg::CONV_HEXU) begin
            dig_ch = 8'h37 + {4'd0, dig};
        end else begin
            dig_ch = 8'h57 + {4'd0, dig};
        end
    end

    logic          zp_eff;
    logic [CW-1:0] prec_eff, len_c, body_len, nbody;
    logic [1:0]    npre_c;
    logic [7:0]    p0_c, p1_c;

    always_comb begin
        numeric = !(conv_reg == icf_pkg::CONV_CHAR || conv_reg == icf_pkg::CONV_PCT);
        nbody = CW'(k_reg);
        zp_eff = zp_reg;
        prec_eff = '0;
        npre_c = '0;
        p0_c = 8'h30;
        p1_c = 8'h78;
        if (numeric) begin
            if (pg_reg) begin
                zp_eff = 1'b0;
                prec_eff = prec_reg;
            end
            if (conv_reg == icf_pkg::CONV_DEC) begin
                if (neg_reg) begin
                    npre_c = 2'd1; p0_c = 8'h2D;
                end else if (plus_reg) begin
                    npre_c = 2'd1; p0_c = 8'h2B;
                end else if (blank_reg) begin
                    npre_c = 2'd1; p0_c = 8'h20;
                end
            end
            if (alt_reg && nz_reg) begin
                if (conv_reg == icf_pkg::CONV_OCT && prec_eff <= nbody) begin
                    npre_c = 2'd1;
                end
                if (conv_reg == icf_pkg::CONV_HEXL || conv_reg == icf_pkg::CONV_PTR) begin
                    npre_c = 2'd2;
                end
                if (conv_reg == icf_pkg::CONV_HEXU) begin
                    npre_c = 2'd2; p1_c = 8'h58;
                end
            end
        end
        body_len = (nbody >= prec_eff) ? nbody : prec_eff;
        len_c = CW'(npre_c) + body_len;
    end

    assign status.digits_done = !numeric ||
                                (dig_final && ((v_nx == 64'd0) ||
                                 (k_reg == KW'(icf_pkg::DIGIT_SLOTS - 1))));

    logic [7:0]    ch;
    logic          seg_end;

    always_comb begin
        ch = 8'h20;
        seg_end = 1'b1;
        unique case (seg_reg)
            icf_pkg::SEG_PRE_A, icf_pkg::SEG_PRE_B: begin
                ch = (cnt_reg == '0) ? pre0_reg : pre1_reg;
                seg_end = (cnt_reg + 1'b1) >= CW'(npre_reg);
            end
            icf_pkg::SEG_LPAD: begin
                ch = zp_reg ? 8'h30 : 8'h20;
                seg_end = (cnt_reg + 1'b1) >= pad_reg;
            end
            icf_pkg::SEG_PZERO: begin
                ch = 8'h30;
                seg_end = (cnt_reg + 1'b1) >= pz_reg;
            end
            icf_pkg::SEG_BODY: begin
                ch = digits_reg[DW'(CW'(k_reg) - 1'b1 - cnt_reg)];
                seg_end = (cnt_reg + 1'b1) >= CW'(k_reg);
            end
            icf_pkg::SEG_RPAD: begin
                seg_end = (cnt_reg + 1'b1) >= pad_reg;
            end
            default: begin
                seg_end = 1'b1;
            end
        endcase
    end

    // Skips segments of zero length starting from a given segment.
    function automatic icf_pkg::seg_t next_live(
        input icf_pkg::seg_t from, input logic zp, input logic left,
        input logic [1:0] np, input logic [CW-1:0] pad, input logic [CW-1:0] pz
    );
        icf_pkg::seg_t s;
        s = from;
        for (int i = 0; i < 7; i++) begin
            if (s == icf_pkg::SEG_PRE_A && !(zp && np != 2'd0)) s = icf_pkg::SEG_LPAD;
            if (s == icf_pkg::SEG_LPAD && !(!left && pad != '0)) s = icf_pkg::SEG_PRE_B;
            if (s == icf_pkg::SEG_PRE_B && !(!zp && np != 2'd0)) s = icf_pkg::SEG_PZERO;
            if (s == icf_pkg::SEG_PZERO && pz == '0) s = icf_pkg::SEG_BODY;
            if (s == icf_pkg::SEG_RPAD && !(left && pad != '0)) s = icf_pkg::SEG_DONE;
        end
        return s;
    endfunction

    icf_pkg::seg_t seg_after;

    always_comb begin
        unique case (seg_reg)
            icf_pkg::SEG_PRE_A: seg_after = icf_pkg::SEG_LPAD;
            icf_pkg::SEG_LPAD:  seg_after = icf_pkg::SEG_PRE_B;
            icf_pkg::SEG_PRE_B: seg_after = icf_pkg::SEG_PZERO;
            icf_pkg::SEG_PZERO: seg_after = icf_pkg::SEG_BODY;
            icf_pkg::SEG_BODY:  seg_after = icf_pkg::SEG_RPAD;
            default:            seg_after = icf_pkg::SEG_DONE;
        endcase
        seg_next = seg_end ? next_live(seg_after, zp_reg, left_reg, npre_reg, pad_reg, pz_reg)
                           : seg_reg;
    end

    assign status.emit_done = (seg_next == icf_pkg::SEG_DONE);

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            conv_reg  <= req.conversion;
            alt_reg   <= req.alternate_form;
            zp_reg    <= req.zero_pad || (req.conversion == icf_pkg::CONV_PTR);
            left_reg  <= req.left_align;
            plus_reg  <= req.plus_sign;
            blank_reg <= req.blank_sign;
            pg_reg    <= req.precision_given;
            prec_reg  <= prec_c;
            width_reg <= (req.conversion == icf_pkg::CONV_PTR && width_c == '0)
                         ? CW'(icf_pkg::PTR_DIGITS) : width_c;
            neg_reg   <= neg;
            nz_reg    <= (mag != 64'd0);
            v_reg     <= mag;
            k_reg     <= '0;
            phase_reg <= '0;
            if (req.conversion == icf_pkg::CONV_CHAR) begin
                digits_reg[0] <= req.value[7:0];
            end else begin
                digits_reg[0] <= 8'h25;
            end
        end
        if (cmd.digit_step) begin
            if (!numeric) begin
                k_reg <= KW'(1);
            end else if (!dig_final) begin
                qacc_reg  <= (phase_reg == 2'd0) ? q_s0 : q_s1b;
                phase_reg <= phase_reg + 1'b1;
            end else begin
                digits_reg[DW'(k_reg)] <= dig_ch;
                k_reg <= k_reg + 1'b1;
                v_reg <= v_nx;
                phase_reg <= '0;
            end
        end
        if (cmd.plan) begin
            zp_reg   <= zp_eff;
            pre0_reg <= p0_c;
            pre1_reg <= p1_c;
            npre_reg <= npre_c;
            pad_reg  <= (width_reg > len_c) ? width_reg - len_c : '0;
            pz_reg   <= (prec_eff > nbody) ? prec_eff - nbody : '0;
            cnt_reg  <= '0;
            seg_reg  <= next_live(icf_pkg::SEG_PRE_A, zp_eff, left_reg, npre_c,
                                  (width_reg > len_c) ? width_reg - len_c : '0,
                                  (prec_eff > nbody) ? prec_eff - nbody : '0);
        end
        if (cmd.emit_step) begin
            seg_reg <= seg_next;
            cnt_reg <= seg_end ? '0 : cnt_reg + 1'b1;
            result_reg.out_char <= ch;
            result_reg.last <= (seg_next == icf_pkg::SEG_DONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            strobe_reg <= 1'b0;
        end else begin
            strobe_reg <= cmd.emit_step;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the integer conversion formatter: directed and random conversions, checked per beat.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    logic               clk;
    logic               rst_n;
    logic               start;
    icf_pkg::conv_in_t  request;
    logic               busy;
    logic               strobe;
    icf_pkg::char_out_t result;

    icf_pkg::conv_in_t  pending_convs[$];
    icf_pkg::char_out_t expected_chars[$];
    int        error_count;
    int        gap_left;
    bit        stimulus_done;
    bit        drain_request;

    integer_conversion_formatter u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .strobe  (strobe),
        .result  (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void push_char(logic [7:0] c);
        icf_pkg::char_out_t r;
        r.out_char = c;
        r.last = 1'b0;
        expected_chars.push_back(r);
    endfunction

    function automatic void predict_text(icf_pkg::conv_in_t c);
        logic [7:0]  prefix[2];
        logic [7:0]  digits[icf_pkg::DIGIT_SLOTS];
        logic [7:0]  ch;
        logic [63:0] mag;
        logic [63:0] v;
        logic [63:0] s;
        logic [3:0]  d;
        int          n_prefix;
        int          n_digits;
        int          wid;
        int          prec;
        int          span;
        int          pad;
        int          shift;
        bit          zp;
        bit          lng;
        bit          neg;
        logic [7:0]  hex_base;
        n_prefix = 0;
        n_digits = 0;
        wid = (c.field_width > 64) ? 64 : c.field_width;
        prec = (c.precision > 62) ? 62 : c.precision;
        zp = c.zero_pad;
        lng = c.long_argument;
        mag = '0;
        if (c.conversion == icf_pkg::CONV_CHAR || c.conversion == icf_pkg::CONV_PCT)
        begin
            digits[0] = (c.conversion == icf_pkg::CONV_CHAR) ? c.value[7:0] : 8'h25;
            n_digits = 1;
            prec = 0;
        end
        else
        begin
            if (c.conversion == icf_pkg::CONV_PTR)
            begin
                lng = 1'b1;
                zp = 1'b1;
                if (wid == 0)
                    wid = icf_pkg::PTR_DIGITS;
            end
            if (c.conversion == icf_pkg::CONV_DEC)
            begin
                s = lng ? c.value : {{32{c.value[31]}}, c.value[31:0]};
                neg = s[63];
                mag = neg ? -s : s;
                if (neg)
                begin
                    prefix[n_prefix] = "-";
                    n_prefix++;
                end
                else if (c.plus_sign)
                begin
                    prefix[n_prefix] = "+";
                    n_prefix++;
                end
                else if (c.blank_sign)
                begin
                    prefix[n_prefix] = " ";
                    n_prefix++;
                end
            end
            else
                mag = lng ? c.value : {32'd0, c.value[31:0]};
            shift = 0;
            hex_base = 8'h57;
            if (c.conversion == icf_pkg::CONV_OCT)
                shift = 3;
            else if (c.conversion == icf_pkg::CONV_HEXL || c.conversion == icf_pkg::CONV_PTR)
                shift = 4;
            else if (c.conversion == icf_pkg::CONV_HEXU)
            begin
                shift = 4;
                hex_base = 8'h37;
            end
            v = mag;
            do
            begin
                if (shift == 3)
                begin
                    d = {1'b0, v[2:0]};
                    v = v >> 3;
                end
                else if (shift == 4)
                begin
                    d = v[3:0];
                    v = v >> 4;
                end
                else
                begin
                    d = 4'(v % 10);
                    v = v / 10;
                end
                ch = (d < 10) ? 8'h30 + d : hex_base + d;
                for (int i = n_digits; i > 0; i--)
                    digits[i] = digits[i - 1];
                digits[0] = ch;
                n_digits++;
            end
            while (v != 0 && n_digits < icf_pkg::DIGIT_SLOTS);
            if (c.precision_given)
                zp = 1'b0;
            else
                prec = 0;
            if (c.alternate_form && mag != 0)
            begin
                if (c.conversion == icf_pkg::CONV_OCT && prec <= n_digits)
                begin
                    prefix[n_prefix] = "0";
                    n_prefix++;
                end
                if (c.conversion == icf_pkg::CONV_HEXL || c.conversion == icf_pkg::CONV_HEXU
                    || c.conversion == icf_pkg::CONV_PTR)
                begin
                    prefix[0] = "0";
                    prefix[1] = (c.conversion == icf_pkg::CONV_HEXU) ? "X" : "x";
                    n_prefix = 2;
                end
            end
        end
        span = n_prefix + ((n_digits >= prec) ? n_digits : prec);
        pad = (wid > span) ? wid - span : 0;
        if (zp)
            for (int i = 0; i < n_prefix; i++)
                push_char(prefix[i]);
        if (!c.left_align)
            for (int i = 0; i < pad; i++)
                push_char(zp ? "0" : " ");
        if (!zp)
            for (int i = 0; i < n_prefix; i++)
                push_char(prefix[i]);
        for (int i = n_digits; i < prec; i++)
            push_char("0");
        for (int i = 0; i < n_digits; i++)
            push_char(digits[i]);
        if (c.left_align)
            for (int i = 0; i < pad; i++)
                push_char(" ");
        expected_chars[$].last = 1'b1;
    endfunction

    function automatic icf_pkg::conv_in_t random_conv();
        icf_pkg::conv_in_t c;
        c = '0;
        c.conversion = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 4))
            0: c.value = 64'($urandom_range(0, 20));
            1: c.value = {32'($urandom), 32'($urandom)};
            2: c.value = -64'($urandom_range(1, 20));
            3: c.value = {32'd0, 32'($urandom)};
            default: c.value = 64'h1 << $urandom_range(0, 63);
        endcase
        c.long_argument = 1'($urandom);
        c.alternate_form = 1'($urandom);
        c.zero_pad = 1'($urandom);
        c.left_align = ($urandom_range(0, 3) == 0);
        c.blank_sign = 1'($urandom);
        c.plus_sign = 1'($urandom);
        c.field_width = ($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'($urandom_range(0, 24));
        c.precision_given = 1'($urandom);
        c.precision = ($urandom_range(0, 5) == 0) ? 6'($urandom) : 6'($urandom_range(0, 24));
        return c;
    endfunction

    function automatic icf_pkg::conv_in_t make_conv(logic [2:0] conv, logic [63:0] value,
                                                    logic [7:0] flags, logic [6:0] wid,
                                                    logic pg, logic [5:0] prec);
        icf_pkg::conv_in_t c;
        c.conversion = conv;
        c.value = value;
        {c.long_argument, c.alternate_form, c.zero_pad, c.left_align,
         c.blank_sign, c.plus_sign} = flags[5:0];
        c.field_width = wid;
        c.precision_given = pg;
        c.precision = prec;
        return c;
    endfunction

    initial
    begin
        pending_convs.push_back(make_conv(icf_pkg::CONV_DEC, 64'h0, 8'h00, 7'd0, 1'b1, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_DEC, 64'h8000_0000, 8'h01, 7'd20,
                                          1'b0, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_DEC, 64'h8000_0000_0000_0000, 8'h20,
                                          7'd0, 1'b0, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_DEC, 64'd42, 8'h03, 7'd8, 1'b0, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_DEC, 64'd42, 8'h02, 7'd8, 1'b0, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_DEC, 64'hFFFF_FFFF, 8'h08, 7'd10,
                                          1'b1, 6'd5));
        pending_convs.push_back(make_conv(icf_pkg::CONV_UNS, 64'hFFFF_FFFF_FFFF_FFFF, 8'h23,
                                          7'd127, 1'b0, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_UNS, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00,
                                          7'd0, 1'b1, 6'd63));
        pending_convs.push_back(make_conv(icf_pkg::CONV_OCT, 64'o777, 8'h10, 7'd6, 1'b0, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_OCT, 64'o7, 8'h10, 7'd0, 1'b1, 6'd4));
        pending_convs.push_back(make_conv(icf_pkg::CONV_OCT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h30,
                                          7'd0, 1'b0, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_HEXL, 64'hBEEF, 8'h18, 7'd10,
                                          1'b0, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_HEXL, 64'h0, 8'h10, 7'd4, 1'b0, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_HEXU, 64'hDEAD_BEEF_CAFE, 8'h34,
                                          7'd30, 1'b0, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_PTR, 64'h1234, 8'h00, 7'd0, 1'b0, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_PTR, 64'hABCD, 8'h10, 7'd20,
                                          1'b1, 6'd2));
        pending_convs.push_back(make_conv(icf_pkg::CONV_CHAR, 64'h41, 8'h3F, 7'd5, 1'b1, 6'd9));
        pending_convs.push_back(make_conv(icf_pkg::CONV_CHAR, 64'hFF, 8'h00, 7'd0, 1'b0, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_PCT, 64'h0, 8'h08, 7'd3, 1'b0, 6'd0));
        pending_convs.push_back(make_conv(icf_pkg::CONV_PCT, 64'h0, 8'h04, 7'd64, 1'b0, 6'd0));
        for (int i = 0; i < 300; i++)
            pending_convs.push_back(random_conv());
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // A start is considered accepted when it is sampled high with busy low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
            gap_left <= 0;
            stimulus_done <= 1'b0;
            drain_request <= 1'b0;
        end
        else if (start && busy)
        begin
        end
        else if (start)
        begin
            predict_text(request);
            start <= 1'b0;
            gap_left <= $urandom_range(0, 13) * ($urandom_range(0, 3) != 0);
            if (pending_convs.size() == 170)
                drain_request <= 1'b1;
        end
        else if (gap_left != 0)
        begin
            if (!busy)
                gap_left <= gap_left - 1;
        end
        else if (pending_convs.size() != 0)
        begin
            if (!(drain_request && expected_chars.size() != 0))
            begin
                start <= 1'b1;
                request <= pending_convs.pop_front();
                drain_request <= 1'b0;
            end
        end
        else
            stimulus_done <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected beat char=%h last=%b", $time,
                         result.out_char, result.last);
                error_count++;
            end
            else
            begin
                if (result.out_char !== expected_chars[0].out_char)
                begin
                    $display("%0t: out_char expected %h actual %h", $time,
                             expected_chars[0].out_char, result.out_char);
                    error_count++;
                end
                if (result.last !== expected_chars[0].last)
                begin
                    $display("%0t: last expected %b actual %b", $time,
                             expected_chars[0].last, result.last);
                    error_count++;
                end
                void'(expected_chars.pop_front());
            end
        end
    end

    initial
    begin
        error_count = 0;
        wait (stimulus_done && expected_chars.size() == 0);
        repeat (100) @(posedge clk);
        if (error_count == 0 && expected_chars.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
